// ----- design/blcm3_pkg.sv -----
// types, constants and microcode program of the bounded three-period lcm search
package blcm3_pkg;

  localparam int FIELD_W             = 16;
  localparam int ITER_W              = 16;
  localparam int WIDE_W              = 32;
  localparam int STATUS_W            = 2;
  localparam int PERIOD_BITS_DEFAULT = 16;
  localparam int NUM_LANES           = 3;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd10000;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_LIMIT = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] period_a;
    logic [FIELD_W-1:0] period_b;
    logic [FIELD_W-1:0] period_c;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WIDE_W-1:0]   common_multiple;
    logic [ITER_W-1:0]   iterations_used;
    logic [WIDE_W-1:0]   count_a;
    logic [WIDE_W-1:0]   count_b;
    logic [WIDE_W-1:0]   count_c;
  } out_beat_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_LATCH,
    OP_CHECK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_SRCH_INIT,
    OP_ADVANCE,
    OP_NOP,
    OP_SET_FOUND,
    OP_SET_MISS,
    OP_SET_ZERO,
    OP_EMIT
  } uop_t;

  // sequencing conditions
  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_WAIT_IN,
    JC_ZERO,
    JC_DIV_BUSY,
    JC_LIMIT,
    JC_NO_HIT,
    JC_WAIT_OUT
  } ucond_t;

  typedef logic [1:0] lane_t;
  localparam lane_t LANE_A = 2'd0;
  localparam lane_t LANE_B = 2'd1;
  localparam lane_t LANE_C = 2'd2;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // program addresses
  localparam upc_t U_IDLE      = 5'd0;
  localparam upc_t U_CHECK     = 5'd1;
  localparam upc_t U_DIVA_INIT = 5'd2;
  localparam upc_t U_DIVA_STEP = 5'd3;
  localparam upc_t U_DIVA_SAVE = 5'd4;
  localparam upc_t U_DIVB_INIT = 5'd5;
  localparam upc_t U_DIVB_STEP = 5'd6;
  localparam upc_t U_DIVB_SAVE = 5'd7;
  localparam upc_t U_DIVC_INIT = 5'd8;
  localparam upc_t U_DIVC_STEP = 5'd9;
  localparam upc_t U_DIVC_SAVE = 5'd10;
  localparam upc_t U_SRCH_INIT = 5'd11;
  localparam upc_t U_ADVANCE   = 5'd12;
  localparam upc_t U_TEST      = 5'd13;
  localparam upc_t U_FOUND     = 5'd14;
  localparam upc_t U_MISS      = 5'd15;
  localparam upc_t U_ZERO      = 5'd16;
  localparam upc_t U_EMIT      = 5'd17;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    lane_t  sel;
    upc_t   target;
  } uword_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{OP_NOP, JC_ALWAYS, LANE_A, U_IDLE};
    unique case (pc)
      U_IDLE:      w = '{OP_LATCH,     JC_WAIT_IN,  LANE_A, U_IDLE};
      U_CHECK:     w = '{OP_CHECK,     JC_ZERO,     LANE_A, U_ZERO};
      U_DIVA_INIT: w = '{OP_DIV_INIT,  JC_NONE,     LANE_A, U_IDLE};
      U_DIVA_STEP: w = '{OP_DIV_STEP,  JC_DIV_BUSY, LANE_A, U_DIVA_STEP};
      U_DIVA_SAVE: w = '{OP_DIV_SAVE,  JC_NONE,     LANE_A, U_IDLE};
      U_DIVB_INIT: w = '{OP_DIV_INIT,  JC_NONE,     LANE_B, U_IDLE};
      U_DIVB_STEP: w = '{OP_DIV_STEP,  JC_DIV_BUSY, LANE_B, U_DIVB_STEP};
      U_DIVB_SAVE: w = '{OP_DIV_SAVE,  JC_NONE,     LANE_B, U_IDLE};
      U_DIVC_INIT: w = '{OP_DIV_INIT,  JC_NONE,     LANE_C, U_IDLE};
      U_DIVC_STEP: w = '{OP_DIV_STEP,  JC_DIV_BUSY, LANE_C, U_DIVC_STEP};
      U_DIVC_SAVE: w = '{OP_DIV_SAVE,  JC_NONE,     LANE_C, U_IDLE};
      U_SRCH_INIT: w = '{OP_SRCH_INIT, JC_NONE,     LANE_A, U_IDLE};
      U_ADVANCE:   w = '{OP_ADVANCE,   JC_LIMIT,    LANE_A, U_MISS};
      U_TEST:      w = '{OP_NOP,       JC_NO_HIT,   LANE_A, U_ADVANCE};
      U_FOUND:     w = '{OP_SET_FOUND, JC_ALWAYS,   LANE_A, U_EMIT};
      U_MISS:      w = '{OP_SET_MISS,  JC_ALWAYS,   LANE_A, U_EMIT};
      U_ZERO:      w = '{OP_SET_ZERO,  JC_NONE,     LANE_A, U_IDLE};
      U_EMIT:      w = '{OP_EMIT,      JC_WAIT_OUT, LANE_A, U_IDLE};
      default:     w = '{OP_NOP,       JC_ALWAYS,   LANE_A, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- design/bounded_lcm_of_three.sv -----
// bounded lcm search over three periods, microcoded sequencer and datapath
// steps from input beat to result: latch the periods, take the largest and check
//   for a zero period, divide the largest by each period, initialise the search,
//   then advance/test until a find or max_iterations; a zero period skips to emit
// throughput: one item at a time; the three remainder divisions of the shared
//   divider and the advance/test loop of the sequencer set the figure
// reset: sequencer returns to idle, max_iterations to 10000, output register empty
module bounded_lcm_of_three
  import blcm3_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ITER_W-1:0]  cfg_data
);

  // effective period width: the fields carry 16 bits, only the low min(PERIOD_BITS, 16) count
  localparam int PW    = (PERIOD_BITS < FIELD_W) ? PERIOD_BITS : FIELD_W;
  // width of a multiple of the largest period and of each quotient count
  localparam int MW    = PW + ITER_W;
  localparam int DCNT_W = $clog2(PW + 1);

  // sequencer
  upc_t   pc;
  upc_t   pc_next;
  uword_t cw;

  // configuration
  logic [ITER_W-1:0] max_iterations;

  // operands
  logic [PW-1:0] per [NUM_LANES];
  logic [PW-1:0] big;
  logic [PW-1:0] big_c;
  logic          any_zero;

  // shared restoring divider: big / per[sel]
  logic [PW-1:0]     div_rem;
  logic [PW-1:0]     div_quo;
  logic [DCNT_W-1:0] dcnt;
  logic [PW-1:0]     divisor;
  logic [PW:0]       div_sh;
  logic              div_ge;

  // per-lane big mod period and big / period
  logic [PW-1:0] rem_l [NUM_LANES];
  logic [PW-1:0] quo_l [NUM_LANES];

  // search state: current multiple, its index, residues and quotients
  logic [MW-1:0]     mul;
  logic [ITER_W-1:0] iter;
  logic [PW-1:0]     res  [NUM_LANES];
  logic [MW-1:0]     cnt  [NUM_LANES];
  logic [PW-1:0]     res_next [NUM_LANES];
  logic [MW-1:0]     cnt_next [NUM_LANES];
  logic              at_limit;
  logic              hit;

  status_t res_status;

  assign cw        = ucode(pc);
  assign in_ready  = (cw.op == OP_LATCH);
  assign cfg_ready = 1'b1;

  assign any_zero = (per[0] == '0) || (per[1] == '0) || (per[2] == '0);
  assign at_limit = (iter == max_iterations);
  assign hit      = (res[0] == '0) && (res[1] == '0) && (res[2] == '0);

  // largest of the three periods
  always_comb begin
    big_c = per[0];
    if (per[1] > big_c) begin
      big_c = per[1];
    end
    if (per[2] > big_c) begin
      big_c = per[2];
    end
  end

  // one restoring divide step: shift in the next dividend bit, subtract if it fits
  assign divisor = per[cw.sel];
  assign div_sh  = {div_rem, div_quo[PW-1]};
  assign div_ge  = (div_sh >= {1'b0, divisor});

  // residue lanes: adding big advances each residue by big mod period, with at most
  // one wrap, and each quotient by big / period plus the wrap
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      logic [PW:0] s;
      logic        wrap;
      s           = {1'b0, res[k]} + {1'b0, rem_l[k]};
      wrap        = (s >= {1'b0, per[k]});
      res_next[k] = wrap ? PW'(s - {1'b0, per[k]}) : s[PW-1:0];
      cnt_next[k] = cnt[k] + MW'(quo_l[k]) + MW'(wrap);
    end
  end

  // next program address
  always_comb begin
    pc_next = pc + 1'b1;
    unique case (cw.cond)
      JC_NONE: begin
      end
      JC_ALWAYS: begin
        pc_next = cw.target;
      end
      JC_WAIT_IN: begin
        if (!in_valid) begin
          pc_next = pc;
        end
      end
      JC_ZERO: begin
        if (any_zero) begin
          pc_next = cw.target;
        end
      end
      JC_DIV_BUSY: begin
        if (dcnt != DCNT_W'(1)) begin
          pc_next = cw.target;
        end
      end
      JC_LIMIT: begin
        if (at_limit) begin
          pc_next = cw.target;
        end
      end
      JC_NO_HIT: begin
        if (!hit) begin
          pc_next = cw.target;
        end
      end
      JC_WAIT_OUT: begin
        // hold while the previous result still sits unclaimed
        if (out_valid && !out_ready) begin
          pc_next = pc;
        end else begin
          pc_next = cw.target;
        end
      end
      default: begin
        pc_next = U_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= U_IDLE;
      out_valid      <= 1'b0;
      max_iterations <= MAX_ITER_RESET;
    end else begin
      pc <= pc_next;
      if (cfg_valid) begin
        max_iterations <= cfg_data;
      end
      if (cw.op == OP_EMIT && !(out_valid && !out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath, driven by the current control word
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LATCH: begin
        if (in_valid) begin
          per[0] <= PW'(in_data.period_a);
          per[1] <= PW'(in_data.period_b);
          per[2] <= PW'(in_data.period_c);
        end
      end
      OP_CHECK: begin
        big <= big_c;
      end
      OP_DIV_INIT: begin
        div_rem <= '0;
        div_quo <= big;
        dcnt    <= DCNT_W'(PW);
      end
      OP_DIV_STEP: begin
        div_rem <= div_ge ? PW'(div_sh - {1'b0, divisor}) : div_sh[PW-1:0];
        div_quo <= {div_quo[PW-2:0], div_ge};
        dcnt    <= dcnt - 1'b1;
      end
      OP_DIV_SAVE: begin
        rem_l[cw.sel] <= div_rem;
        quo_l[cw.sel] <= div_quo;
      end
      OP_SRCH_INIT: begin
        mul  <= '0;
        iter <= '0;
        for (int k = 0; k < NUM_LANES; k++) begin
          res[k] <= '0;
          cnt[k] <= '0;
        end
      end
      OP_ADVANCE: begin
        if (!at_limit) begin
          mul  <= mul + MW'(big);
          iter <= iter + 1'b1;
          for (int k = 0; k < NUM_LANES; k++) begin
            res[k] <= res_next[k];
            cnt[k] <= cnt_next[k];
          end
        end
      end
      OP_SET_FOUND: begin
        res_status <= ST_FOUND;
      end
      OP_SET_MISS: begin
        res_status <= ST_LIMIT;
      end
      OP_SET_ZERO: begin
        res_status <= ST_ZERO;
      end
      OP_EMIT: begin
        if (!(out_valid && !out_ready)) begin
          out_data.status <= res_status;
          if (res_status == ST_FOUND) begin
            out_data.common_multiple <= WIDE_W'(mul);
            out_data.iterations_used <= iter;
            out_data.count_a         <= WIDE_W'(cnt[0]);
            out_data.count_b         <= WIDE_W'(cnt[1]);
            out_data.count_c         <= WIDE_W'(cnt[2]);
          end else begin
            out_data.common_multiple <= '0;
            out_data.iterations_used <= '0;
            out_data.count_a         <= '0;
            out_data.count_b         <= '0;
            out_data.count_c         <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // the divide counter never wraps through zero during a step
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIV_STEP) |-> (dcnt != '0))
    else $error("divide step with exhausted counter");

  // residues stay reduced below their periods while searching
  a_res_reduced: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_NOP) |-> (res[0] < per[0]) && (res[1] < per[1]) && (res[2] < per[2]))
    else $error("residue not reduced");

  // the multiple index never passes the configured limit
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_NOP) |-> (iter <= max_iterations))
    else $error("multiple index beyond limit");

  // a result that is not a find carries only zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_FOUND) |->
      (out_data.common_multiple == '0) && (out_data.iterations_used == '0) &&
      (out_data.count_a == '0) && (out_data.count_b == '0) && (out_data.count_c == '0))
    else $error("nonzero fields on a miss");

  // a find has a nonzero multiple and index
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_FOUND) |->
      (out_data.common_multiple != '0) && (out_data.iterations_used != '0))
    else $error("empty find");

endmodule
